// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with an active-low reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

// ----- hw/rtl/tpgr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgr_pkg
// Shared types, constants and helpers of the trace point grid resampler.
// ----------------------------------------------------------------------------
package tpgr_pkg;

    // coordinate width (Q24.8 at 32 bits)
    localparam int CW    = 32;
    localparam int CNT_W = $clog2(CW);

    typedef logic signed [CW-1:0] t_coord;

    localparam t_coord C_MAX    = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord C_MIN    = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord STEP_RST = t_coord'(256);

    // configuration register indexes
    localparam logic [1:0] REG_STEP = 2'd0;
    localparam logic [1:0] REG_WLO  = 2'd1;
    localparam logic [1:0] REG_WHI  = 2'd2;

    typedef struct packed {
        t_coord step;
        t_coord wlo;
        t_coord whi;
    } t_cfg;

    // classified input word
    typedef struct packed {
        logic   first;
        t_coord x;
        t_coord y;
        t_coord z;
        logic   pass;   // pass-through mode
        logic   win_x;  // x inside window
    } t_item;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_res;

    typedef struct packed {
        logic            start;
        logic [CW-1:0]   dividend;
        logic [CW-2:0]   divisor;
    } t_rem_req;

    typedef struct packed {
        logic            done;
        logic [CW-2:0]   rem;
    } t_rem_rsp;

    function automatic logic f_in_win(input t_coord v, input t_cfg c);
        f_in_win = (v >= c.wlo) && (v <= c.whi);
    endfunction

endpackage

// ----- hw/rtl/trace_point_grid_resampler_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_point_grid_resampler_top
// Resamples a stream of (x, y, z) Q24.8 points onto a regular grid along x.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the point word and raise push; it is taken
//   on an edge with push high and full low. Result side is a queue: the
//   oldest result sits on o_out_* while empty is low and leaves on an edge
//   with pop high. Each point yields zero or one result.
//   Config: i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready is always
//   high. Index 0 step, 1 window low, 2 window high; others are ignored.
//   Write only while the block is drained.
// Flow:
//   A popped point is registered, then evaluated; its result is written
//   into the result queue. When the grid mark falls more than one step
//   behind x, the back end waits on the bit-serial remainder unit (32 steps).
//   A two-entry input queue keeps accepting while the back end works.
// Reset: queues empty, line state and grid mark zero, registers default.
//   A stalled receiver fills the result queue; the back end then holds,
//   and the input queue fills and raises full.
// ----------------------------------------------------------------------------
module trace_point_grid_resampler_top import tpgr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_first_point,
    input  t_coord      i_x_coord,
    input  t_coord      i_y_coord,
    input  t_coord      i_z_value,
    output logic        empty,
    input  logic        pop,
    output t_coord      o_out_x,
    output t_coord      o_out_y,
    output t_coord      o_out_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  t_coord      i_cfg_data
);

    t_cfg      r_cfg;
    logic      w_valid;
    t_item     w_item;
    logic      w_pop;
    logic      w_oq_full;
    logic      w_push;
    t_res      w_res;
    t_res      w_out;
    t_rem_req  w_rem_req;
    t_rem_rsp  w_rem_rsp;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step <= STEP_RST;
            r_cfg.wlo  <= C_MIN;
            r_cfg.whi  <= C_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_STEP: r_cfg.step <= i_cfg_data;
                REG_WLO:  r_cfg.wlo  <= i_cfg_data;
                REG_WHI:  r_cfg.whi  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    tpgr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_push  (push),
        .o_full  (full),
        .i_first (i_first_point),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .i_z     (i_z_value),
        .o_valid (w_valid),
        .o_item  (w_item),
        .i_pop   (w_pop)
    );

    tpgr_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rem_req),
        .o_rsp   (w_rem_rsp)
    );

    tpgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (w_valid),
        .i_item    (w_item),
        .o_pop     (w_pop),
        .i_oq_full (w_oq_full),
        .o_push    (w_push),
        .o_res     (w_res),
        .o_rem_req (w_rem_req),
        .i_rem_rsp (w_rem_rsp)
    );

    tpgr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_res   (w_res),
        .o_full  (w_oq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (w_out)
    );

    assign o_out_x = w_out.x;
    assign o_out_y = w_out.y;
    assign o_out_z = w_out.z;

endmodule

// ----- hw/rtl/tpgr_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgr_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tpgr_front import tpgr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_push,
    output logic   o_full,
    input  logic   i_first,
    input  t_coord i_x,
    input  t_coord i_y,
    input  t_coord i_z,
    output logic   o_valid,
    output t_item  o_item,
    input  logic   i_pop
);

    t_item       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_item       w_item;
    logic        w_wr;
    logic        w_rd;

    // classification
    always_comb begin
        w_item.first = i_first;
        w_item.x     = i_x;
        w_item.y     = i_y;
        w_item.z     = i_z;
        w_item.pass  = (i_cfg.step <= t_coord'(0));
        w_item.win_x = f_in_win(i_x, i_cfg);
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) r_wptr <= ~r_wptr;
            if (w_rd) r_rptr <= ~r_rptr;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/tpgr_rem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgr_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tpgr_rem import tpgr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [CW-1:0]     r_div;
    logic [CW-2:0]     r_dsr;
    logic [CW-2:0]     r_rem;
    logic [CW-1:0]     w_trial;
    logic [CW-1:0]     w_diff;
    logic [CW-2:0]     n_rem;

    // one restoring step
    always_comb begin
        w_trial = {r_rem, r_div[CW-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        n_rem   = (w_trial >= {1'b0, r_dsr}) ? w_diff[CW-2:0] : w_trial[CW-2:0];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_div <= i_req.dividend;
            r_dsr <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[CW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(CW-1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

// ----- hw/rtl/tpgr_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgr_back
// Line tracking, grid-mark comparison, point selection and mark advance.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpgr_back import tpgr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_item    i_item,
    output logic     o_pop,
    input  logic     i_oq_full,
    output logic     o_push,
    output t_res     o_res,
    output t_rem_req o_rem_req,
    input  t_rem_rsp i_rem_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_ADJ  = 2'd3;

    logic [1:0]     r_state;
    t_item          r_item;
    t_coord         r_px;
    t_coord         r_py;
    t_coord         r_pz;
    t_coord         r_mark;
    logic [CW-2:0]  r_addend;
    logic           r_rzero;

    logic            w_line;
    t_coord          w_px;
    t_coord          w_py;
    t_coord          w_pz;
    t_coord          w_mark;
    logic            w_between;
    logic signed [CW:0] w_sp;
    logic signed [CW:0] w_sc;
    logic [CW:0]     w_ap;
    logic [CW:0]     w_ac;
    logic            w_pick_prev;
    logic [CW-1:0]   w_d;
    logic [CW-2:0]   w_step;
    logic            w_mark_ge;
    logic            w_d_lt;
    logic            w_d_eq;
    t_coord          w_adv;
    t_coord          w_adj;

    // a + b for positive b, saturated at the most positive coordinate
    function automatic t_coord f_sat_add(input t_coord a, input logic [CW-2:0] b);
        logic signed [CW:0] s;
        s = {a[CW-1], a} + {2'b00, b};
        if (s[CW] == 1'b0 && s[CW-1] == 1'b1) begin
            f_sat_add = C_MAX;
        end else begin
            f_sat_add = s[CW-1:0];
        end
    endfunction

    // effective previous point and mark (line start restarts both)
    always_comb begin
        w_line = r_item.first || (r_py != r_item.y);
        w_px   = w_line ? r_item.x : r_px;
        w_py   = w_line ? r_item.y : r_py;
        w_pz   = w_line ? r_item.z : r_pz;
        w_mark = w_line ? r_item.x : r_mark;
    end

    // bracket test and nearer point
    always_comb begin
        w_between = ((w_px <= w_mark) && (r_item.x >= w_mark)) ||
                    ((w_px >= w_mark) && (r_item.x <= w_mark));
        w_sp = {w_px[CW-1], w_px} - {w_mark[CW-1], w_mark};
        w_sc = {r_item.x[CW-1], r_item.x} - {w_mark[CW-1], w_mark};
        w_ap = w_sp[CW] ? -w_sp : w_sp;
        w_ac = w_sc[CW] ? -w_sc : w_sc;
        w_pick_prev = (w_ap[CW-1:0] < w_ac[CW-1:0]) && !r_item.pass;
    end

    // mark advance decisions
    always_comb begin
        w_step    = i_cfg.step[CW-2:0];
        w_d       = r_item.x - w_mark;
        w_mark_ge = (w_mark >= r_item.x);
        w_d_lt    = (w_d < {1'b0, w_step});
        w_d_eq    = (w_d == {1'b0, w_step});
        w_adv     = f_sat_add(w_mark, w_step);
        w_adj     = r_rzero ? r_item.x : f_sat_add(r_item.x, r_addend);
    end

    // result word
    always_comb begin
        if (w_pick_prev) begin
            o_res.x = w_px;
            o_res.y = w_py;
            o_res.z = w_pz;
        end else begin
            o_res.x = r_item.x;
            o_res.y = r_item.y;
            o_res.z = r_item.z;
        end
        o_push = 1'b0;
        if (r_state == S_EVAL) begin
            if (r_item.pass) begin
                o_push = r_item.win_x;
            end else if (w_between) begin
                o_push = w_pick_prev ? f_in_win(w_px, i_cfg) : r_item.win_x;
            end
        end
    end

    assign o_pop = (r_state == S_IDLE) && i_valid && !i_oq_full;

    assign o_rem_req.start    = (r_state == S_EVAL) && !r_item.pass && w_between &&
                                !w_mark_ge && !w_d_lt && !w_d_eq;
    assign o_rem_req.dividend = w_d;
    assign o_rem_req.divisor  = w_step;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        if (r_state == S_WAIT && i_rem_rsp.done) begin
            r_rzero  <= (i_rem_rsp.rem == '0);
            r_addend <= w_step - i_rem_rsp.rem;
        end
    end

    // sequencer and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_px    <= '0;
            r_py    <= '0;
            r_pz    <= '0;
            r_mark  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_state <= S_IDLE;
                    if (!r_item.pass) begin
                        r_px <= r_item.x;
                        r_py <= r_item.y;
                        r_pz <= r_item.z;
                        if (!w_between) begin
                            r_mark <= w_mark;
                        end else if (w_mark_ge || w_d_lt) begin
                            r_mark <= w_adv;
                        end else if (w_d_eq) begin
                            r_mark <= r_item.x;
                        end else begin
                            r_mark  <= w_mark;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (i_rem_rsp.done) r_state <= S_ADJ;
                end
                S_ADJ: begin
                    r_mark  <= w_adj;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    `ASSERT_PROP(a_push_room, i_clk, i_rst_n, o_push |-> !i_oq_full, "result push into full queue")
    `ASSERT_PROP(a_pop_eval, i_clk, i_rst_n, o_pop |=> r_state == S_EVAL, "popped word not evaluated")
    `ASSERT_PROP(a_start_wait, i_clk, i_rst_n, o_rem_req.start |=> r_state == S_WAIT, "remainder start lost")
    `ASSERT_PROP(a_done_wait, i_clk, i_rst_n, i_rem_rsp.done |-> r_state == S_WAIT, "unexpected remainder done")

endmodule

// ----- hw/rtl/tpgr_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpgr_outq
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module tpgr_outq import tpgr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    t_res        r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        w_wr;
    logic        w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_res;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) r_wptr <= ~r_wptr;
            if (w_rd) r_rptr <= ~r_rptr;
            r_cnt <= n_cnt;
        end
    end

endmodule
